### rtl/vag_pkg.sv
// Shared types and constants for the block ADPCM decoder.
// Used by the front end, the queue, the back end and the top level.
package vag_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] POS_HEADER = 4'd0;
   localparam logic [3:0] POS_FLAGS  = 4'd1;
   localparam logic [3:0] POS_LAST   = 4'd15;

   localparam logic [3:0] FILTER_MAX = 4'd4;
   localparam logic [2:0] FILTER_BAD = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] shift_range;
      logic [2:0] filter_select;
      logic [2:0] block_flags;
      logic       block_last;
      logic       clear_hist;
   } entry_type;

   function automatic logic [7:0] coef_one(input logic [2:0] filt);
      logic [7:0] c;
      unique case (filt)
         3'd1:    c = 8'd60;
         3'd2:    c = 8'd115;
         3'd3:    c = 8'd98;
         3'd4:    c = 8'd122;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] coef_two(input logic [2:0] filt);
      logic [7:0] c;
      unique case (filt)
         3'd2:    c = 8'd52;
         3'd3:    c = 8'd55;
         3'd4:    c = 8'd60;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

### rtl/vag_queue.sv
// Two-entry queue of decoded block bytes between front and back end.
// Depends on vag_pkg for the entry type and depth.
module vag_queue import vag_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/vag_front.sv
// Front end: accepts compressed bytes, tracks block position and header.
// Pushes data bytes with their block context into the queue; uses vag_pkg.
module vag_front import vag_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_sample_start,
   output logic       push,
   output entry_type  push_entry,
   input  logic       queue_full
);

   logic [3:0] pos_ff, pos_in;
   logic [3:0] shift_ff, shift_in;
   logic [2:0] filter_ff, filter_in;
   logic [2:0] flags_ff, flags_in;
   logic       clear_ff, clear_in;
   logic       accept;
   logic [3:0] cur_pos;
   logic       clear_now;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign cur_pos   = req_sample_start ? POS_HEADER : pos_ff;
   assign clear_now = req_sample_start || clear_ff;

   always_comb begin
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      filter_in = filter_ff;
      flags_in  = flags_ff;
      clear_in  = clear_ff;
      push      = 1'b0;
      push_entry.data_byte     = req_data_byte;
      push_entry.shift_range   = shift_ff;
      push_entry.filter_select = filter_ff;
      push_entry.block_flags   = flags_ff;
      push_entry.block_last    = (cur_pos == POS_LAST);
      push_entry.clear_hist    = clear_now;
      if (accept) begin
         pos_in = cur_pos + 4'd1;
         priority if (cur_pos == POS_HEADER) begin
            shift_in  = req_data_byte[3:0];
            filter_in = ({1'b0, req_data_byte[7:4]} > {1'b0, FILTER_MAX})
                        ? FILTER_BAD : req_data_byte[6:4];
            clear_in  = clear_now;
         end else if (cur_pos == POS_FLAGS) begin
            flags_in = req_data_byte[2:0];
            clear_in = clear_now;
         end else begin
            push     = 1'b1;
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         shift_ff  <= '0;
         filter_ff <= '0;
         flags_ff  <= '0;
         clear_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         shift_ff  <= shift_in;
         filter_ff <= filter_in;
         flags_ff  <= flags_in;
         clear_ff  <= clear_in;
      end
   end

endmodule

### rtl/vag_back.sv
// Back end: one predictor step per cycle while not stalled, low nibble then high nibble.
// Holds the sample history and the result register; uses vag_pkg.
module vag_back import vag_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pcm_sample,
   output logic        rsp_block_last,
   output logic        rsp_end_flag,
   output logic        rsp_repeat_flag,
   output logic        rsp_loop_start_flag,
   output logic        rsp_bad_filter
);

   localparam int WIDE_W = 41;
   localparam int QUO_W  = 33;
   localparam logic signed [WIDE_W-1:0] HIST_MAX = WIDE_W'(64'sh7FFF_FFFF);
   localparam logic signed [WIDE_W-1:0] HIST_MIN = -WIDE_W'(64'sh8000_0000);
   localparam logic signed [QUO_W-1:0]  ROUND_BIAS =
      (QUO_W'(1) <<< FRAC_BITS) - QUO_W'(1);
   localparam logic signed [QUO_W-1:0]  PCM_MAX = QUO_W'(32767);
   localparam logic signed [QUO_W-1:0]  PCM_MIN = -QUO_W'(32768);

   logic               phase_ff, phase_in;
   logic signed [31:0] hist1_ff, hist1_in;
   logic signed [31:0] hist2_ff, hist2_in;
   logic               out_valid_ff, out_valid_in;
   logic [15:0]        pcm_ff;
   logic               last_ff;
   logic [2:0]         flags_ff;
   logic               bad_ff;

   logic               fire;
   logic               use_zero;
   logic signed [31:0] h1, h2;
   logic [3:0]         nib;
   logic signed [15:0] raw;
   logic signed [WIDE_W-1:0] prod1, prod2, pred, total;
   logic signed [31:0] hist_new;
   logic signed [QUO_W-1:0] quo;
   logic [15:0]        pcm_new;

   assign fire     = head_valid && (!out_valid_ff || !rsp_stall);
   assign pop      = fire && phase_ff;
   assign use_zero = head_entry.clear_hist && !phase_ff;
   assign h1       = use_zero ? '0 : hist1_ff;
   assign h2       = use_zero ? '0 : hist2_ff;
   assign nib      = phase_ff ? head_entry.data_byte[7:4] : head_entry.data_byte[3:0];
   assign raw      = $signed({nib, 12'b0}) >>> head_entry.shift_range;

   always_comb begin
      prod1 = WIDE_W'(h1) * WIDE_W'($signed({1'b0, coef_one(head_entry.filter_select)}));
      prod2 = WIDE_W'(h2) * WIDE_W'($signed({1'b0, coef_two(head_entry.filter_select)}));
      pred  = prod1 - prod2;
      total = (WIDE_W'(raw) <<< FRAC_BITS) + (pred >>> 6);
      priority if (total > HIST_MAX) begin
         hist_new = 32'sh7FFF_FFFF;
      end else if (total < HIST_MIN) begin
         hist_new = 32'sh8000_0000;
      end else begin
         hist_new = total[31:0];
      end
      if (hist_new < 0) begin
         quo = (QUO_W'(hist_new) + ROUND_BIAS) >>> FRAC_BITS;
      end else begin
         quo = QUO_W'(hist_new) >>> FRAC_BITS;
      end
      priority if (quo > PCM_MAX) begin
         pcm_new = 16'h7FFF;
      end else if (quo < PCM_MIN) begin
         pcm_new = 16'h8000;
      end else begin
         pcm_new = quo[15:0];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      hist1_in     = hist1_ff;
      hist2_in     = hist2_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (fire) begin
         phase_in     = !phase_ff;
         hist1_in     = hist_new;
         hist2_in     = h1;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hist1_ff     <= hist1_in;
         hist2_ff     <= hist2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pcm_ff   <= pcm_new;
         last_ff  <= head_entry.block_last && phase_ff;
         flags_ff <= head_entry.block_flags;
         bad_ff   <= (head_entry.filter_select == FILTER_BAD);
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pcm_sample      = pcm_ff;
   assign rsp_block_last      = last_ff;
   assign rsp_end_flag        = flags_ff[0];
   assign rsp_repeat_flag     = flags_ff[1];
   assign rsp_loop_start_flag = flags_ff[2];
   assign rsp_bad_filter      = bad_ff;

endmodule

### rtl/vag_adpcm_block_decoder.sv
// Top level of the block ADPCM decoder: front end, queue and back end.
// Depends on vag_pkg, vag_front, vag_queue and vag_back.
//
// Usage:
//   req_* carries one compressed byte per beat; req_sample_start marks the
//   first byte of a new sample and clears the history and block position.
//   Bytes 0 and 1 of each 16-byte block (range/filter, flags) give no beat
//   on rsp_*; each later byte gives two rsp_* beats, low nibble first.
//   With the queue empty and the back end idle, an accepted data byte is
//   written into a queue slot; the back end then registers its low-nibble
//   sample and after it the high-nibble sample in the result register.
//   Throughput is set by the single predictor unit in the back end, which
//   runs one history step per cycle while not stalled, two per data byte.
//   Header bytes need no step. A two-entry queue lets the front end take
//   bytes while the back end works or the receiver stalls.
//   When rsp_stall is high the result beat holds; once the queue fills,
//   req_stall rises. Reset clears position, header, history, queue and the
//   result valid; nothing is delivered until new bytes arrive.
module vag_adpcm_block_decoder import vag_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_sample_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pcm_sample,
   output logic        rsp_block_last,
   output logic        rsp_end_flag,
   output logic        rsp_repeat_flag,
   output logic        rsp_loop_start_flag,
   output logic        rsp_bad_filter
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   vag_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_sample_start (req_sample_start),
      .push             (push),
      .push_entry       (push_entry),
      .queue_full       (queue_full)
   );

   vag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   vag_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_entry          (head_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pcm_sample      (rsp_pcm_sample),
      .rsp_block_last      (rsp_block_last),
      .rsp_end_flag        (rsp_end_flag),
      .rsp_repeat_flag     (rsp_repeat_flag),
      .rsp_loop_start_flag (rsp_loop_start_flag),
      .rsp_bad_filter      (rsp_bad_filter)
   );

endmodule
